// ===== sv/voltage_level_table_mapper_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef VOLTAGE_LEVEL_TABLE_MAPPER_CORE_DEFINES_SVH
`define VOLTAGE_LEVEL_TABLE_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VLTM_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VLTM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication that also checks through reset.
`define VLTM_ASSERT_NEXT_ALL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/vltm_pkg.sv =====
`default_nettype none

package vltm_pkg;

    localparam int NUM_RAILS   = 32;
    localparam int MAX_LEVELS  = 128;
    localparam int LEVEL_LIMIT = 128;

    // Transaction field widths
    localparam int REQ_W       = 2;
    localparam int RAIL_FIELD_W = 6;
    localparam int IDX_FIELD_W = 7;
    localparam int LVL_W       = 16;
    localparam int CNT_W       = 8;

    localparam int RAIL_CMP_W  = RAIL_FIELD_W + 1;
    localparam int RAIL_W      = (NUM_RAILS > 1) ? $clog2(NUM_RAILS) : 1;
    localparam int IDX_W       = $clog2(MAX_LEVELS);
    localparam int ADDR_W      = RAIL_W + IDX_W;
    localparam int RAM_DEPTH   = NUM_RAILS << IDX_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_MAP   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_COUNT = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERLIMIT = 2'd2
    } t_status;

    typedef struct packed {
        t_req_kind               req_type;
        logic [RAIL_FIELD_W-1:0] rail;
        logic [IDX_FIELD_W-1:0]  level_index;
        logic [LVL_W-1:0]        level_value;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [IDX_FIELD_W-1:0] hw_index;
        logic [LVL_W-1:0]       mapped_level;
        logic [CNT_W-1:0]       entry_count;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [LVL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              we;
        logic [RAIL_W-1:0] rail;
        logic [CNT_W-1:0]  count;
        logic              ended;
    } t_rail_upd;

endpackage

`default_nettype wire

// ===== sv/voltage_level_table_mapper_core.sv =====
// Voltage level table mapper.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one request transaction:
// load an entry, map a level to a hardware index, read a level, or query a count.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns one result per request.
// The block handles one request at a time; o_in_stall stays high from acceptance until
// the result moves into the output register.
// Load, count, invalid-rail and out-of-range read requests go from execute to done;
// a read passes through a read-wait state, and a map scans the table before done.
// A new request is taken in the cycle after the result is registered, never before.
// Map throughput is set by the single read port of the level memory: the shared
// compare unit checks one table entry per cycle, in the cycle after the entry is read.
// Reset clears per-rail counts and end flags and empties the output register;
// table entries are not cleared and are only ever read below a rail's count.
// While the receiver stalls, the result holds; a new request may still be accepted,
// and its result waits in the block until the output register frees up.
`default_nettype none

module voltage_level_table_mapper_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  vltm_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output vltm_pkg::t_out_item  o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RDWAIT,
        S_DONE
    } t_state;

    localparam vltm_pkg::t_out_item RES_INVALID = '{
        status: vltm_pkg::ST_INVALID, hw_index: '0, mapped_level: '0, entry_count: '0
    };

    // Control registers
    t_state                       r_state, n_state;
    logic                         r_out_vld, n_out_vld;
    logic                         r_cmp_vld, n_cmp_vld;
    // Payload registers
    vltm_pkg::t_in_item           r_req, n_req;
    vltm_pkg::t_out_item          r_res, n_res;
    vltm_pkg::t_out_item          r_out, n_out;
    logic [vltm_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [vltm_pkg::IDX_W-1:0]   r_cmp_idx, n_cmp_idx;

    logic [vltm_pkg::RAIL_W-1:0]  rail_sel;
    logic [vltm_pkg::CNT_W-1:0]   rail_cnt;
    logic                         rail_ended;
    logic [vltm_pkg::LVL_W-1:0]   ram_rd;
    vltm_pkg::t_ram_req           ram_req;
    vltm_pkg::t_rail_upd          rail_upd;

    logic                         rail_ok;
    logic                         pos_zero;
    logic [vltm_pkg::CNT_W-1:0]   cnt_eff;
    logic                         ended_eff;
    logic                         load_ok;
    logic                         end_mark;
    logic                         idx_ok;
    logic                         issue;
    logic                         hit;
    logic                         out_free;
    logic [vltm_pkg::IDX_W-1:0]   pos_idx;

    assign rail_sel = r_req.rail[vltm_pkg::RAIL_W-1:0];
    assign pos_idx  = r_req.level_index[vltm_pkg::IDX_W-1:0];
    assign rail_ok  = {1'b0, r_req.rail} < vltm_pkg::RAIL_CMP_W'(vltm_pkg::NUM_RAILS);

    // A load at position 0 restarts the rail before the order check.
    assign pos_zero  = (r_req.level_index == '0);
    assign cnt_eff   = pos_zero ? '0 : rail_cnt;
    assign ended_eff = pos_zero ? 1'b0 : rail_ended;
    assign load_ok   = !ended_eff
                     && ({1'b0, r_req.level_index} == cnt_eff)
                     && (cnt_eff < vltm_pkg::CNT_W'(vltm_pkg::MAX_LEVELS))
                     && (cnt_eff < vltm_pkg::CNT_W'(vltm_pkg::LEVEL_LIMIT));
    // A zero entry past position 0 closes the table and is not counted.
    assign end_mark  = (r_req.level_value == '0) && !pos_zero;

    assign idx_ok   = {1'b0, r_req.level_index} < rail_cnt;
    assign issue    = r_idx < rail_cnt;
    // Shared compare: entry read last cycle against the requested level.
    assign hit      = r_cmp_vld && (ram_rd >= r_req.level_value);
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        rail_upd.we    = (r_state == S_EXEC) && rail_ok
                       && (r_req.req_type == vltm_pkg::REQ_LOAD) && load_ok;
        rail_upd.rail  = rail_sel;
        rail_upd.count = end_mark ? cnt_eff : cnt_eff + 1'b1;
        rail_upd.ended = end_mark;

        ram_req.we    = rail_upd.we;
        ram_req.waddr = {rail_sel, pos_idx};
        ram_req.wdata = r_req.level_value;
        ram_req.re    = ((r_state == S_EXEC) && rail_ok
                        && (r_req.req_type == vltm_pkg::REQ_READ) && idx_ok)
                      || ((r_state == S_SCAN) && issue);
        ram_req.raddr = (r_state == S_SCAN) ? {rail_sel, r_idx[vltm_pkg::IDX_W-1:0]}
                                            : {rail_sel, pos_idx};
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_res     = r_res;
        n_out     = r_out;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        // Drop the output once taken; refill below.
        n_out_vld = r_out_vld && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = RES_INVALID;
                n_state = S_DONE;
                if (rail_ok) begin
                    case (r_req.req_type)
                        vltm_pkg::REQ_LOAD: begin
                            if (load_ok) begin
                                n_res.status = vltm_pkg::ST_OK;
                            end
                        end
                        vltm_pkg::REQ_MAP: begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        vltm_pkg::REQ_READ: begin
                            if (idx_ok) begin
                                n_state = S_RDWAIT;
                            end
                        end
                        vltm_pkg::REQ_COUNT: begin
                            n_res.status      = vltm_pkg::ST_OK;
                            n_res.entry_count = rail_cnt;
                        end
                        default: begin
                            n_res = RES_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_res.status       = vltm_pkg::ST_OK;
                    n_res.hw_index     = vltm_pkg::IDX_FIELD_W'(r_cmp_idx);
                    n_res.mapped_level = ram_rd;
                    n_state            = S_DONE;
                end else if (!issue && !r_cmp_vld) begin
                    n_res.status = vltm_pkg::ST_OVERLIMIT;
                    n_state      = S_DONE;
                end else if (issue) begin
                    // Advance the read pointer; compare this entry next cycle.
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[vltm_pkg::IDX_W-1:0];
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_RDWAIT: begin
                n_res.status       = vltm_pkg::ST_OK;
                n_res.mapped_level = ram_rd;
                n_state            = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_res     <= n_res;
        r_out     <= n_out;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    vltm_rail_regs u_rail_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rail  (rail_sel),
        .i_upd   (rail_upd),
        .o_count (rail_cnt),
        .o_ended (rail_ended)
    );

    vltm_level_ram u_level_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd)
    );

endmodule

`default_nettype wire

// ===== sv/vltm_level_ram.sv =====
`default_nettype none

module vltm_level_ram (
    input  wire                      i_clk,
    input  vltm_pkg::t_ram_req       i_req,
    output logic [vltm_pkg::LVL_W-1:0] o_rd_data
);

    logic [vltm_pkg::LVL_W-1:0] r_mem [vltm_pkg::RAM_DEPTH];
    logic [vltm_pkg::LVL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/vltm_rail_regs.sv =====
`default_nettype none

module vltm_rail_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [vltm_pkg::RAIL_W-1:0]   i_rail,
    input  vltm_pkg::t_rail_upd          i_upd,
    output logic [vltm_pkg::CNT_W-1:0]   o_count,
    output logic                         o_ended
);

    logic [vltm_pkg::CNT_W-1:0] r_count [vltm_pkg::NUM_RAILS];
    logic [vltm_pkg::NUM_RAILS-1:0] r_ended;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vltm_pkg::NUM_RAILS; i++) begin
                r_count[i] <= '0;
            end
            r_ended <= '0;
        end else if (i_upd.we) begin
            r_count[i_upd.rail] <= i_upd.count;
            r_ended[i_upd.rail] <= i_upd.ended;
        end
    end

    assign o_count = r_count[i_rail];
    assign o_ended = r_ended[i_rail];

endmodule

`default_nettype wire

// ===== sv/vltm_checker.sv =====
`default_nettype none
`include "voltage_level_table_mapper_core_defines.svh"

module vltm_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input vltm_pkg::t_out_item o_out_data
);

    `VLTM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    `VLTM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accepting a transaction")

    `VLTM_ASSERT_NOW(a_fail_zero_fields, o_out_valid && (o_out_data.status != vltm_pkg::ST_OK), (o_out_data.hw_index == '0) && (o_out_data.mapped_level == '0) && (o_out_data.entry_count == '0), "non-ok result carries nonzero fields")

    `VLTM_ASSERT_NEXT_ALL(a_reset_empty, !i_rst_n, !o_out_valid, "output valid after reset")

endmodule

bind voltage_level_table_mapper_core vltm_checker u_vltm_checker (.*);

`default_nettype wire

// ===== tb/sv/voltage_level_table_mapper_core_test.sv =====
`timescale 1ns / 1ps

module voltage_level_table_mapper_core_test;

    localparam int ITEM_TARGET = 800;
    // The slowest request is a map over a full table.
    localparam int DRAIN_TAIL  = 140;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;

    // Shadow copy of the per-rail level tables; it produces the expected result of
    // every accepted request and checks the results in order.
    class level_table_scoreboard;
        logic [vltm_pkg::LVL_W-1:0] levels [vltm_pkg::NUM_RAILS][vltm_pkg::MAX_LEVELS];
        int unsigned                counts [vltm_pkg::NUM_RAILS];
        bit                         ended  [vltm_pkg::NUM_RAILS];
        vltm_pkg::t_out_item        pending [$];
        int                         failures;
        int                         checked;

        function void clear_tables();
            foreach (counts[r]) begin
                counts[r] = 0;
                ended[r]  = 1'b0;
            end
            pending.delete();
            failures = 0;
            checked  = 0;
        endfunction

        function vltm_pkg::t_out_item predict(vltm_pkg::t_in_item it);
            vltm_pkg::t_out_item r;
            int unsigned         cnt;
            r = '0;
            r.status = vltm_pkg::ST_INVALID;
            if (it.rail >= vltm_pkg::NUM_RAILS)
                return r;
            case (it.req_type)
                vltm_pkg::REQ_LOAD: begin
                    // position 0 starts the table over
                    if (it.level_index == 0) begin
                        counts[it.rail] = 0;
                        ended[it.rail]  = 1'b0;
                    end
                    cnt = counts[it.rail];
                    if (ended[it.rail] || it.level_index != cnt ||
                        cnt >= vltm_pkg::MAX_LEVELS || cnt >= vltm_pkg::LEVEL_LIMIT)
                        return r;
                    levels[it.rail][it.level_index] = it.level_value;
                    if (it.level_value == 0 && it.level_index != 0)
                        ended[it.rail] = 1'b1;
                    else
                        counts[it.rail] = cnt + 1;
                    r.status = vltm_pkg::ST_OK;
                end
                vltm_pkg::REQ_MAP: begin
                    r.status = vltm_pkg::ST_OVERLIMIT;
                    for (int i = 0; i < counts[it.rail]; i++) begin
                        if (levels[it.rail][i] >= it.level_value) begin
                            r.status       = vltm_pkg::ST_OK;
                            r.hw_index     = i[vltm_pkg::IDX_FIELD_W-1:0];
                            r.mapped_level = levels[it.rail][i];
                            break;
                        end
                    end
                end
                vltm_pkg::REQ_READ: begin
                    if (it.level_index < counts[it.rail]) begin
                        r.status       = vltm_pkg::ST_OK;
                        r.mapped_level = levels[it.rail][it.level_index];
                    end
                end
                default: begin
                    r.status      = vltm_pkg::ST_OK;
                    r.entry_count = counts[it.rail][vltm_pkg::CNT_W-1:0];
                end
            endcase
            return r;
        endfunction

        function void note_request(vltm_pkg::t_in_item it);
            pending.push_back(predict(it));
        endfunction

        function void check_result(vltm_pkg::t_out_item got);
            vltm_pkg::t_out_item exp;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("result with nothing expected: st=%0d idx=%0d lvl=%h cnt=%0d",
                             got.status, got.hw_index, got.mapped_level, got.entry_count);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.status !== exp.status || got.hw_index !== exp.hw_index ||
                got.mapped_level !== exp.mapped_level || got.entry_count !== exp.entry_count)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display({"mismatch: exp st=%0d idx=%0d lvl=%h cnt=%0d,",
                              " got st=%0d idx=%0d lvl=%h cnt=%0d"},
                             exp.status, exp.hw_index, exp.mapped_level, exp.entry_count,
                             got.status, got.hw_index, got.mapped_level, got.entry_count);
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    vltm_pkg::t_in_item  in_data   = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    vltm_pkg::t_out_item out_data;

    level_table_scoreboard sb;
    int  items_sent  = 0;
    int  cycle_count = 0;
    int  hold_left   = 0;
    bit  no_idle     = 1'b0;

    voltage_level_table_mapper_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Hold the result channel stalled for a drawn number of cycles before each result.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Check every result transaction at the edge that accepts it.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
            hold_left = draw_gap();
        end
    end

    function automatic vltm_pkg::t_in_item mk(vltm_pkg::t_req_kind kind, int unsigned rail,
                                              int unsigned idx, int unsigned val);
        vltm_pkg::t_in_item it;
        it.req_type    = kind;
        it.rail        = rail[vltm_pkg::RAIL_FIELD_W-1:0];
        it.level_index = idx[vltm_pkg::IDX_FIELD_W-1:0];
        it.level_value = val[vltm_pkg::LVL_W-1:0];
        return it;
    endfunction

    // Present one request transaction after a drawn gap; valid stays high after
    // acceptance until the next falling edge decides what comes next.
    task automatic send_item(vltm_pkg::t_in_item it);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_request(it);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(mk(vltm_pkg::REQ_COUNT, 0, 0, 0));          // empty rail count
        send_item(mk(vltm_pkg::REQ_MAP, 0, 0, 0));            // map on an empty table
        send_item(mk(vltm_pkg::REQ_READ, 0, 0, 0));           // read on an empty table
        send_item(mk(vltm_pkg::REQ_LOAD, 32, 0, 16'h1234));   // first rail out of range
        send_item(mk(vltm_pkg::REQ_MAP, 63, 127, 16'hFFFF));  // top rail number
        send_item(mk(vltm_pkg::REQ_COUNT, 63, 0, 0));
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 1, 5));           // out-of-order position
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 0, 0));           // zero at position 0 counts
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 1, 100));
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 2, 200));
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 3, 16'hFFFF));
        send_item(mk(vltm_pkg::REQ_MAP, 1, 0, 0));
        send_item(mk(vltm_pkg::REQ_MAP, 1, 0, 150));
        send_item(mk(vltm_pkg::REQ_MAP, 1, 0, 200));          // exact hit
        send_item(mk(vltm_pkg::REQ_MAP, 1, 0, 16'hFFFF));
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 4, 0));           // zero ends the table
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 4, 7));           // ended table rejects
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 5, 7));
        send_item(mk(vltm_pkg::REQ_COUNT, 1, 0, 0));
        send_item(mk(vltm_pkg::REQ_READ, 1, 3, 0));
        send_item(mk(vltm_pkg::REQ_READ, 1, 4, 0));           // index at the count
        send_item(mk(vltm_pkg::REQ_READ, 1, 127, 0));
        send_item(mk(vltm_pkg::REQ_LOAD, 31, 0, 16'hFFFF));   // last valid rail
        send_item(mk(vltm_pkg::REQ_MAP, 31, 0, 16'hFFFF));
        send_item(mk(vltm_pkg::REQ_LOAD, 1, 0, 50));          // restart shrinks the table
        send_item(mk(vltm_pkg::REQ_MAP, 1, 0, 60));           // above highest level
    endtask

    // Fill one rail to its last position, then exercise the full table.
    task automatic fill_full_table(int unsigned rail);
        int unsigned top;
        no_idle = ($urandom_range(0, 1) == 0);
        top = 0;
        for (int p = 0; p < vltm_pkg::MAX_LEVELS; p++) begin
            top = p * 500 + $urandom_range(1, 400);
            send_item(mk(vltm_pkg::REQ_LOAD, rail, p, top));
        end
        // full table rejects
        send_item(mk(vltm_pkg::REQ_LOAD, rail, vltm_pkg::MAX_LEVELS - 1, 9));
        send_item(mk(vltm_pkg::REQ_COUNT, rail, 0, 0));
        send_item(mk(vltm_pkg::REQ_MAP, rail, 0, 16'hFFFF));          // scans every entry
        send_item(mk(vltm_pkg::REQ_MAP, rail, 0, top));
        send_item(mk(vltm_pkg::REQ_READ, rail, vltm_pkg::MAX_LEVELS - 1, 0));
        send_item(mk(vltm_pkg::REQ_READ, rail,
                     $urandom_range(0, vltm_pkg::MAX_LEVELS - 1), 0));
    endtask

    // Well-formed table load with random content, followed by queries on it.
    task automatic table_session();
        logic [vltm_pkg::LVL_W-1:0] vals [$];
        logic [vltm_pkg::LVL_W-1:0] v;
        int unsigned                rail;
        int unsigned                len;
        int unsigned                base;
        int unsigned                pick;
        bit                         sorted;
        rail   = $urandom_range(0, vltm_pkg::NUM_RAILS - 1);
        len    = $urandom_range(1, 12);
        sorted = ($urandom_range(0, 3) != 0);
        base   = $urandom_range(0, 2000);
        for (int p = 0; p < len; p++) begin
            if (sorted) begin
                v = base[vltm_pkg::LVL_W-1:0];
                base += $urandom_range(1, 5000);
            end else begin
                v = $urandom_range(0, 16'hFFFF);
            end
            vals.push_back(v);
            send_item(mk(vltm_pkg::REQ_LOAD, rail, p, v));
            // occasionally break the sequence with a stray position
            if ($urandom_range(0, 15) == 0)
                send_item(mk(vltm_pkg::REQ_LOAD, rail, $urandom_range(p + 2, 127),
                             $urandom));
        end
        if ($urandom_range(0, 1) == 0) begin
            send_item(mk(vltm_pkg::REQ_LOAD, rail, len, 0));
            if ($urandom_range(0, 2) == 0)
                send_item(mk(vltm_pkg::REQ_LOAD, rail, len + $urandom_range(0, 1),
                             $urandom));
        end
        repeat ($urandom_range(2, 8)) begin
            pick = $urandom_range(0, vals.size() - 1);
            case ($urandom_range(0, 2))
                0: begin
                    case ($urandom_range(0, 3))
                        0: v = vals[pick];
                        1: v = vals[pick] + 1'b1;
                        2: v = $urandom_range(0, 16'hFFFF);
                        default: v = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    endcase
                    send_item(mk(vltm_pkg::REQ_MAP, rail, $urandom_range(0, 127), v));
                end
                1: send_item(mk(vltm_pkg::REQ_READ, rail,
                                ($urandom_range(0, 2) != 0) ? pick : $urandom_range(0, 127),
                                $urandom_range(0, 16'hFFFF)));
                default: send_item(mk(vltm_pkg::REQ_COUNT, rail, $urandom_range(0, 127),
                                      $urandom));
            endcase
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 8))
            send_item(mk(vltm_pkg::t_req_kind'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 127), $urandom_range(0, 16'hFFFF)));
    endtask

    initial begin
        bit second_fill;
        second_fill = 1'b0;
        sb = new();
        sb.clear_tables();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain_results();
        fill_full_table($urandom_range(0, vltm_pkg::NUM_RAILS - 1));

        while (items_sent < ITEM_TARGET) begin
            if (!second_fill && items_sent >= ITEM_TARGET / 2) begin
                second_fill = 1'b1;
                fill_full_table($urandom_range(0, vltm_pkg::NUM_RAILS - 1));
            end
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: table_session();
                6, 7:             send_noise();
                default:          drain_results();
            endcase
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Sent %0d requests (loads, maps, reads, counts, bad rails, two full tables);",
                 items_sent);
        $display("checked %0d results, %0d failures, %0d results never arrived.",
                 sb.checked, sb.failures, sb.pending.size());
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
